### hw/rtl/utf8d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared types, constants and lead-byte helpers for the UTF-8 decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

	// Code point width and the replacement character.
	localparam int unsigned CP_W = 21;
	localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ASM,
		ST_DONE
	} utf8d_state_t;

	// Sequence length called for by a lead byte; zero for an invalid lead.
	function automatic logic [2:0] lead_length(input logic [7:0] c);
		logic [2:0] len;
		begin
			if (c[7] == 1'b0) begin
				len = 3'd1;
			end else if (c[7:5] == 3'b110) begin
				len = 3'd2;
			end else if (c[7:4] == 4'b1110) begin
				len = 3'd3;
			end else if (c[7:3] == 5'b11110) begin
				len = 3'd4;
			end else begin
				len = 3'd0;
			end
			return len;
		end
	endfunction

	// Payload bits that a lead byte contributes to the code point.
	function automatic logic [CP_W-1:0] lead_bits(input logic [7:0] c, input logic [2:0] len);
		logic [CP_W-1:0] bits;
		begin
			unique case (len)
				3'd2:    bits = {16'd0, c[4:0]};
				3'd3:    bits = {17'd0, c[3:0]};
				3'd4:    bits = {18'd0, c[2:0]};
				default: bits = {13'd0, c};
			endcase
			return bits;
		end
	endfunction

endpackage

### hw/rtl/utf8_decoder_with_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder with replacement
// Decodes a byte stream into code points, one byte per accepted word. Bad
// leads and broken sequences give U+FFFD, and the bytes after a broken lead
// are taken again as new leads.
// ----------------------------------------------------------------------------
//  Channel  Dir  tdata               tuser      tlast
//  s_axis   in   [7:0] in_byte       -          final_byte
//  m_axis   out  [20:0] code_point   run_last   stream_end
//
//  A byte that only adds to a pending sequence passes through the idle,
//  scan and done states; each result it causes and each continuation byte
//  checked adds a sequencer step, done by the single check-and-assemble step.
//  s_axis_tready is high only while the sequencer waits for a byte.
//  A stalled output holds the sequencer wherever it needs to hand over a word.
//  Reset clears the pending byte count and the sequencer at once.
// ----------------------------------------------------------------------------
module utf8_decoder_with_replacement (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tlast,   // final_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
	output logic        m_axis_tuser,   // [0] run_last
	output logic        m_axis_tlast    // stream_end
);
	import utf8d_pkg::*;

	utf8d_state_t st_q, st_d;

	// Pending bytes, oldest in entry 0.
	logic [7:0]      buf_q [4];
	logic [7:0]      buf_sh [4];
	logic [2:0]      cnt_q;
	logic            fin_q;

	// Assembly registers for one multi-byte sequence.
	logic [CP_W-1:0] acc_q;
	logic [2:0]      len_q;
	logic [1:0]      idx_q;
	logic [7:0]      chk_q [3];

	// Held result, waiting to learn whether it is the last of its byte.
	logic            hold_valid_q;
	logic [CP_W-1:0] hold_cp_q;

	// Output register.
	logic            out_valid_q;
	logic [CP_W-1:0] out_cp_q;
	logic            out_last_q;
	logic            out_end_q;

	// Sequencer controls.
	logic            accept;
	logic            produce;
	logic [CP_W-1:0] prod_cp;
	logic [2:0]      cons_len;
	logic            asm_load;
	logic            asm_shift;
	logic            flush;
	logic            drop;
	logic            out_free;
	logic            produce_ok;
	logic [7:0]      lead;
	logic [2:0]      lead_len;
	logic [7:0]      cont;
	logic            cont_ok;
	logic            asm_last;
	logic            out_load;

	assign accept     = s_axis_tvalid && s_axis_tready;
	assign out_free   = !out_valid_q || m_axis_tready;
	assign produce_ok = !hold_valid_q || out_free;
	assign lead       = buf_q[0];
	assign lead_len   = lead_length(lead);
	assign cont       = chk_q[0];
	assign cont_ok    = (cont[7:6] == 2'b10);
	assign asm_last   = (({1'b0, idx_q} + 3'd1) == len_q);
	assign out_load   = (produce && hold_valid_q) || flush;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// Next state and sequencer controls.
	always_comb begin
		st_d          = st_q;
		produce       = 1'b0;
		prod_cp       = REPL_CP;
		cons_len      = 3'd0;
		asm_load      = 1'b0;
		asm_shift     = 1'b0;
		flush         = 1'b0;
		drop          = 1'b0;
		s_axis_tready = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					st_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == 3'd0) begin
					st_d = ST_DONE;
				end else if (lead_len <= 3'd1) begin
					// Invalid lead or plain ASCII: one result, one byte used.
					if (produce_ok) begin
						produce  = 1'b1;
						prod_cp  = (lead_len == 3'd0) ? REPL_CP : {13'd0, lead};
						cons_len = 3'd1;
					end
				end else if (cnt_q < lead_len) begin
					st_d = ST_DONE;
				end else begin
					asm_load = 1'b1;
					st_d     = ST_ASM;
				end
			end
			ST_ASM: begin
				if (!cont_ok) begin
					// Broken sequence: replace the lead, replay the rest.
					if (produce_ok) begin
						produce  = 1'b1;
						prod_cp  = REPL_CP;
						cons_len = 3'd1;
						st_d     = ST_SCAN;
					end
				end else if (asm_last) begin
					if (produce_ok) begin
						produce  = 1'b1;
						prod_cp  = {acc_q[CP_W-7:0], cont[5:0]};
						cons_len = len_q;
						st_d     = ST_SCAN;
					end
				end else begin
					asm_shift = 1'b1;
				end
			end
			ST_DONE: begin
				if (fin_q && (cnt_q != 3'd0)) begin
					// Stream ended inside a sequence.
					if (produce_ok) begin
						produce = 1'b1;
						prod_cp = REPL_CP;
						drop    = 1'b1;
					end
				end else if (hold_valid_q) begin
					if (out_free) begin
						flush = 1'b1;
						st_d  = ST_IDLE;
					end
				end else begin
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	// Pending buffer after removing the bytes of one finished step.
	always_comb begin
		buf_sh[0] = buf_q[0];
		buf_sh[1] = buf_q[1];
		buf_sh[2] = buf_q[2];
		buf_sh[3] = buf_q[3];
		unique case (cons_len)
			3'd1: begin
				buf_sh[0] = buf_q[1];
				buf_sh[1] = buf_q[2];
				buf_sh[2] = buf_q[3];
			end
			3'd2: begin
				buf_sh[0] = buf_q[2];
				buf_sh[1] = buf_q[3];
			end
			3'd3: begin
				buf_sh[0] = buf_q[3];
			end
			default: begin
				buf_sh[0] = buf_q[0];
			end
		endcase
	end

	// Byte count and end-of-stream flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			fin_q <= 1'b0;
		end else if (accept) begin
			cnt_q <= cnt_q + 3'd1;
			fin_q <= s_axis_tlast;
		end else if (drop) begin
			cnt_q <= 3'd0;
		end else if (cons_len != 3'd0) begin
			cnt_q <= cnt_q - cons_len;
		end
	end

	// Pending byte storage.
	always_ff @(posedge clk) begin
		if (accept) begin
			buf_q[cnt_q[1:0]] <= s_axis_tdata;
		end else if (cons_len != 3'd0) begin
			buf_q <= buf_sh;
		end
	end

	// Shared check-and-assemble unit: one continuation byte per cycle unless output stalls.
	always_ff @(posedge clk) begin
		if (asm_load) begin
			acc_q    <= lead_bits(lead, lead_len);
			len_q    <= lead_len;
			idx_q    <= 2'd1;
			chk_q[0] <= buf_q[1];
			chk_q[1] <= buf_q[2];
			chk_q[2] <= buf_q[3];
		end else if (asm_shift) begin
			acc_q    <= {acc_q[CP_W-7:0], cont[5:0]};
			idx_q    <= idx_q + 2'd1;
			chk_q[0] <= chk_q[1];
			chk_q[1] <= chk_q[2];
		end
	end

	// Held result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (produce) begin
			hold_valid_q <= 1'b1;
		end else if (flush) begin
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			hold_cp_q <= prod_cp;
		end
	end

	// Output register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register: payload. A flush marks the last result of the byte.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_cp_q   <= hold_cp_q;
			out_last_q <= flush;
			out_end_q  <= flush && fin_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'd0, out_cp_q};
	assign m_axis_tuser  = out_last_q;
	assign m_axis_tlast  = out_end_q;

`ifndef SYNTH
	// A new byte is only taken once every result of the last one has left the hold stage.
	a_idle_hold_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> !hold_valid_q)
		else $error("hold stage not empty while waiting for a byte");

	// Pending bytes never fill the buffer while the block waits for a byte.
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> (cnt_q <= 3'd3))
		else $error("pending byte count out of range");

	// The end of the stream is always the last result of its byte.
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
		else $error("stream end without run end");

	// After the final byte's results are out, nothing stays pending.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(flush && fin_q) |=> (cnt_q == 3'd0))
		else $error("pending bytes left after end of stream");
`endif

endmodule
